[rtl/core/bit_sliced_range_scan_assert.svh]
// Assertion macros for the bit-sliced range scan.
`ifndef BIT_SLICED_RANGE_SCAN_ASSERT_SVH
`define BIT_SLICED_RANGE_SCAN_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define BSRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bsrs_pkg.sv]
// Shared constants, types and functions of the bit-sliced range scan.
package bsrs_pkg;

	localparam int LANES      = 128;
	localparam int WORD_W     = 64;
	localparam int MAX_SLICES = 32;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;
	localparam int BOUND_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int GRP_W      = 8;
	localparam int TOTAL_W    = 32;
	localparam int IN_W       = 2 * WORD_W;
	localparam int OUT_W      = 2 * WORD_W + GRP_W + TOTAL_W;

	localparam logic [31:0] POP_M1 = 32'h5555_5555;
	localparam logic [31:0] POP_M2 = 32'h3333_3333;
	localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;
	localparam logic [31:0] POP_M8 = 32'h0101_0101;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER = 2'd0,
		REG_UPPER = 2'd1,
		REG_BITS  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
	} lanes_t;

	function automatic logic [WORD_W-1:0] lane_mask(input int word);
		int n;
		n = LANES - WORD_W * word;
		if (n >= WORD_W)
			return '1;
		if (n <= 0)
			return '0;
		return (WORD_W'(1) << n) - WORD_W'(1);
	endfunction

	localparam logic [WORD_W-1:0] LANE_MASK_LO = lane_mask(0);
	localparam logic [WORD_W-1:0] LANE_MASK_HI = lane_mask(1);

	function automatic logic [5:0] pop32(input logic [31:0] x);
		logic [31:0] v;
		logic [31:0] p;
		v = x - ((x >> 1) & POP_M1);
		v = (v & POP_M2) + ((v >> 2) & POP_M2);
		v = (v + (v >> 4)) & POP_M4;
		p = v * POP_M8;
		return p[29:24];
	endfunction

	function automatic logic [6:0] pop64(input logic [63:0] x);
		return 7'(pop32(x[31:0])) + 7'(pop32(x[63:32]));
	endfunction

	// zero reads as one slice, anything above the maximum saturates
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc);
		if (bc == '0)
			return CNT_W'(1);
		if (bc > CNT_W'(MAX_SLICES))
			return CNT_W'(MAX_SLICES);
		return bc;
	endfunction

endpackage

[rtl/core/bsrs_slice.sv]
// Per-lane compare masks, slice counter and the finished-group match register.
module bsrs_slice
	import bsrs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BOUND_W-1:0] lower_bound,
	input  logic [BOUND_W-1:0] upper_bound,
	input  logic [CNT_W-1:0]   bit_count,
	input  logic               in_valid,
	output logic               in_ready,
	input  lanes_t             slice,
	output logic               slice_last,
	output logic               out_valid,
	input  logic               out_ready,
	output lanes_t             match
);

	lanes_t gt_q, lt_q, eql_q, equ_q;
	lanes_t gt_n, lt_n, eql_n, equ_n;
	lanes_t v, c1, c2;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt;
	logic             accept;
	logic             valid_s1;
	lanes_t           match_s1;

	always_comb begin
		v.lo  = slice.lo & LANE_MASK_LO;
		v.hi  = slice.hi & LANE_MASK_HI;
		c1    = {IN_W{lower_bound[idx_q]}};
		c2    = {IN_W{upper_bound[idx_q]}};
		gt_n  = gt_q | (eql_q & ~c1 & v);
		lt_n  = lt_q | (equ_q & c2 & ~v);
		eql_n = eql_q & ~(v ^ c1);
		equ_n = equ_q & ~(v ^ c2);
	end

	assign cnt        = eff_count(bit_count);
	assign slice_last = ({1'b0, idx_q} + CNT_W'(1)) >= cnt;
	assign in_ready   = !valid_s1 || out_ready;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q  <= '0;
			lt_q  <= '0;
			eql_q <= '1;
			equ_q <= '1;
			idx_q <= '0;
		end else if (accept) begin
			if (slice_last) begin
				gt_q  <= '0;
				lt_q  <= '0;
				eql_q <= '1;
				equ_q <= '1;
				idx_q <= '0;
			end else begin
				gt_q  <= gt_n;
				lt_q  <= lt_n;
				eql_q <= eql_n;
				equ_q <= equ_n;
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= accept && slice_last;
	end

	always_ff @(posedge clk) begin
		if (accept && slice_last) begin
			match_s1.lo <= gt_n.lo & lt_n.lo & LANE_MASK_LO;
			match_s1.hi <= gt_n.hi & lt_n.hi & LANE_MASK_HI;
		end
	end

	assign out_valid = valid_s1;
	assign match     = match_s1;

endmodule

[rtl/core/bsrs_count.sv]
// Population count stage, running total and the result register.
module bsrs_count
	import bsrs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lanes_t             match,
	output logic               out_valid,
	input  logic               out_ready,
	output lanes_t             out_match,
	output logic [GRP_W-1:0]   group_matches,
	output logic [TOTAL_W-1:0] running_total
);

	logic               valid_s2;
	lanes_t             match_s2;
	logic [GRP_W-1:0]   cnt_s2;
	logic               out_valid_q;
	lanes_t             out_match_q;
	logic [GRP_W-1:0]   out_cnt_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_adv;

	assign out_adv  = !out_valid_q || out_ready;
	assign in_ready = !valid_s2 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (in_ready)
				valid_s2 <= in_valid;
			if (out_adv)
				out_valid_q <= valid_s2;
			if (out_adv && valid_s2)
				total_q <= total_q + TOTAL_W'(cnt_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			match_s2 <= match;
			cnt_s2   <= GRP_W'(pop64(match.lo)) + GRP_W'(pop64(match.hi));
		end
		if (out_adv && valid_s2) begin
			out_match_q <= match_s2;
			out_cnt_q   <= cnt_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_match     = out_match_q;
	assign group_matches = out_cnt_q;
	assign running_total = total_q;

endmodule

[rtl/core/bit_sliced_range_scan.sv]
// A group's last slice beat gives its result on m_tvalid through the match, count and result registers.
// Throughput: one slice beat per cycle, one result per group, with no bubbles unless m_tready holds the result path.
// Rate is set by the per-lane mask update and the 128-lane popcount stage.
// Three-register result path (match, count, result) with per-stage ready.
// arst_n low resets masks, slice counter, total, valid flags and the registers
// to lower 0, upper 0, bit count 32.
`include "bit_sliced_range_scan_assert.svh"

module bit_sliced_range_scan
	import bsrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BOUND_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // slice_low, slice_high
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata   // match_low, match_high, group_matches, running_total
);

	logic [BOUND_W-1:0] lower_q;
	logic [BOUND_W-1:0] upper_q;
	logic [CNT_W-1:0]   bits_q;
	lanes_t             slice;
	lanes_t             match_s1;
	lanes_t             out_match;
	logic               s1_valid;
	logic               s2_ready;
	logic               slice_last;
	logic [GRP_W-1:0]   group_matches;
	logic [TOTAL_W-1:0] running_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			bits_q  <= CNT_W'(MAX_SLICES);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				REG_BITS:  bits_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign slice.lo = s_tdata[WORD_W-1:0];
	assign slice.hi = s_tdata[IN_W-1:WORD_W];

	bsrs_slice u_slice (
		.clk         (clk),
		.arst_n      (arst_n),
		.lower_bound (lower_q),
		.upper_bound (upper_q),
		.bit_count   (bits_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.slice       (slice),
		.slice_last  (slice_last),
		.out_valid   (s1_valid),
		.out_ready   (s2_ready),
		.match       (match_s1)
	);

	bsrs_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s1_valid),
		.in_ready      (s2_ready),
		.match         (match_s1),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_match     (out_match),
		.group_matches (group_matches),
		.running_total (running_total)
	);

	assign m_tdata = {running_total, group_matches, out_match.hi, out_match.lo};

	`BSRS_ASSERT_NOW(a_count_is_popcount, m_tvalid, $countones(m_tdata[IN_W-1:0]) == int'(m_tdata[IN_W+GRP_W-1:IN_W]), "group count differs from mask popcount")
	`BSRS_ASSERT_NOW(a_ready_when_empty, !s1_valid, s_tready, "input stalled with empty match stage")
	`BSRS_ASSERT_NEXT(a_last_beat_loads, s_tvalid && s_tready && slice_last, s1_valid, "last slice beat gave no result")

endmodule

[sim/bit_sliced_range_scan_tb.sv]
// Self-checking testbench for the bit-sliced range scan: stream slices in, check group results.
`timescale 1ns / 1ps

module bit_sliced_range_scan_tb;
	import bsrs_pkg::*;

	localparam int ITEM_TARGET  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_NS     = 2_000_000;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [GRP_W-1:0]   count;
		logic [WORD_W-1:0]  hi;
		logic [WORD_W-1:0]  lo;
	} scan_result_t;

	class range_scan_tracker;
		logic [BOUND_W-1:0] lower;
		logic [BOUND_W-1:0] upper;
		logic [CNT_W-1:0]   bits;
		logic [WORD_W-1:0]  above_lo[2];
		logic [WORD_W-1:0]  below_hi[2];
		logic [WORD_W-1:0]  tie_lo[2];
		logic [WORD_W-1:0]  tie_hi[2];
		logic [IDX_W-1:0]   slice_idx;
		logic [TOTAL_W-1:0] total;
		scan_result_t       pending_matches[$];
		int errors;
		int slices;
		int results;
		int writes;

		function new();
			lower = '0;
			upper = '0;
			bits = CNT_W'(32);
			total = '0;
			rearm();
		endfunction

		function void rearm();
			for (int w = 0; w < 2; w++) begin
				above_lo[w] = '0;
				below_hi[w] = '0;
				tie_lo[w] = '1;
				tie_hi[w] = '1;
			end
			slice_idx = '0;
		endfunction

		function int group_len();
			if (int'(bits) == 0)
				return 1;
			if (int'(bits) > MAX_SLICES)
				return MAX_SLICES;
			return int'(bits);
		endfunction

		function void set_reg(cfg_reg_t r, logic [BOUND_W-1:0] v);
			writes++;
			case (r)
				REG_LOWER: lower = v;
				REG_UPPER: upper = v;
				REG_BITS:  bits = v[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_slice(lanes_t d);
			logic [WORD_W-1:0] c1;
			logic [WORD_W-1:0] c2;
			logic [WORD_W-1:0] v;
			scan_result_t r;
			c1 = {WORD_W{lower[slice_idx]}};
			c2 = {WORD_W{upper[slice_idx]}};
			slices++;
			for (int w = 0; w < 2; w++) begin
				v = (w == 0) ? (d.lo & LANE_MASK_LO) : (d.hi & LANE_MASK_HI);
				above_lo[w] |= tie_lo[w] & ~c1 & v;
				below_hi[w] |= tie_hi[w] & c2 & ~v;
				tie_lo[w] &= ~(v ^ c1);
				tie_hi[w] &= ~(v ^ c2);
			end
			if (int'(slice_idx) + 1 < group_len()) begin
				slice_idx = slice_idx + IDX_W'(1);
				return;
			end
			r.lo = above_lo[0] & below_hi[0] & LANE_MASK_LO;
			r.hi = above_lo[1] & below_hi[1] & LANE_MASK_HI;
			r.count = GRP_W'($countones(r.lo) + $countones(r.hi));
			total = total + TOTAL_W'(r.count);
			r.total = total;
			pending_matches.push_back(r);
			rearm();
		endfunction

		function int pending();
			return pending_matches.size();
		endfunction

		function void field_diff(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(scan_result_t got);
			scan_result_t want;
			results++;
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got %h", $time, got);
				return;
			end
			want = pending_matches.pop_front();
			field_diff("match_low", want.lo, got.lo);
			field_diff("match_high", want.hi, got.hi);
			field_diff("group_matches", WORD_W'(want.count), WORD_W'(got.count));
			field_diff("running_total", WORD_W'(want.total), WORD_W'(got.total));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BOUND_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;  // slice_low, slice_high
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;  // match_low, match_high, group_matches, running_total

	range_scan_tracker sb = new();
	int idle_mode;
	logic hold_req;

	bit_sliced_range_scan i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		case (idle_mode)
			0: return 0;
			1: return $urandom_range(0, 12);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
		endcase
	endfunction

	function automatic lanes_t rand_lanes();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// slices that track a bound keep lanes in the equality masks across the group
	function automatic lanes_t make_slice();
		lanes_t flips;
		int kind;
		flips = rand_lanes() & rand_lanes() & rand_lanes();
		kind = $urandom_range(0, 19);
		if (kind < 8)
			return rand_lanes();
		if (kind < 13)
			return {IN_W{sb.lower[sb.slice_idx]}} ^ flips;
		if (kind < 18)
			return {IN_W{sb.upper[sb.slice_idx]}} ^ flips;
		return (kind == 18) ? '0 : '1;
	endfunction

	function automatic logic [BOUND_W-1:0] pick_bound();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [BOUND_W-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		sb.set_reg(r, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_slice(input lanes_t d);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		sb.take_slice(d);
	endtask

	// sender pauses until every result is back and the pipeline has drained
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = draw_gap();
			end
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		int bc;
		int len;
		int items;
		int phases;
		int sel;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LOWER;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 1'b0;
		idle_mode = 1;
		phases = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// zero bit count: every slice is a whole group
		write_reg(REG_LOWER, '0);
		write_reg(REG_UPPER, '1);
		write_reg(REG_BITS, '0);
		send_slice('0);
		send_slice('1);
		send_slice({2{64'h5555_5555_5555_5555}});
		send_slice({2{64'haaaa_aaaa_aaaa_aaaa}});

		wait_idle();
		write_reg(REG_UPPER, 32'h3);
		write_reg(REG_BITS, 32'd2);
		repeat (4) send_slice(rand_lanes());

		// oversize count saturates, then lowering it mid-group closes the group at once
		wait_idle();
		write_reg(REG_LOWER, 32'h0000_0012);
		write_reg(REG_UPPER, 32'h0000_002d);
		write_reg(REG_BITS, 32'd63);
		repeat (5) send_slice(make_slice());
		wait_idle();
		write_reg(REG_BITS, 32'd3);
		send_slice(make_slice());

		// long receiver hold-off with the sender flat out
		wait_idle();
		write_reg(REG_BITS, 32'd1);
		idle_mode = 0;
		hold_req = 1'b1;
		repeat (40) send_slice(make_slice());

		wait_idle();
		idle_mode = 2;
		write_reg(REG_LOWER, '0);
		write_reg(REG_UPPER, '1);
		write_reg(REG_BITS, 32'd32);
		repeat (32) send_slice(make_slice());

		while (sb.slices < ITEM_TARGET) begin
			wait_idle();
			phases++;
			idle_mode = $urandom_range(0, 2);
			if ($urandom_range(0, 1))
				write_reg(REG_LOWER, pick_bound());
			if ($urandom_range(0, 1))
				write_reg(REG_UPPER, pick_bound());
			sel = $urandom_range(0, 99);
			if (sel < 95) begin
				if (sel < 70)
					bc = $urandom_range(1, 8);
				else if (sel < 85)
					bc = $urandom_range(9, 32);
				else if (sel < 88)
					bc = 0;
				else
					bc = $urandom_range(33, 63);
				write_reg(REG_BITS, BOUND_W'(bc));
			end
			len = sb.group_len();
			items = (len <= 8) ? len * $urandom_range(1, 12) : len * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0)
				items += $urandom_range(1, len);
			repeat (items) send_slice(make_slice());
		end

		wait_idle();
		$display("Run covered %0d slice beats and %0d group results over %0d random phases,",
			sb.slices, sb.results, phases);
		$display("with %0d register writes and a final running total of %0d.",
			sb.writes, sb.total);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
